[design/lcgx_pkg.sv]
// Shared constants and helpers for the LCG key XOR stream cipher.
// Holds the generator constants, the key alphabet and the default key length.
// No dependencies.
package lcgx_pkg;

	localparam int unsigned KEY_LENGTH_DEF = 32;

	localparam logic [31:0] LCG_MUL = 32'd214013;
	localparam logic [31:0] LCG_ADD = 32'd2531011;

	localparam int unsigned DRAW_W   = 15;
	localparam int unsigned DRAW_LSB = 16;

	localparam int unsigned ALPHA_SIZE = 61;

	// Maps a value below the alphabet size to a-z, A-Z, 1-9.
	function automatic logic [7:0] alpha_char(input logic [5:0] idx);
		logic [7:0] code;
		code = 8'h00;
		if (idx < 6'd26) begin
			code = 8'h61 + 8'(idx);
		end else if (idx < 6'd52) begin
			code = 8'h41 + 8'(idx - 6'd26);
		end else if (idx < 6'(ALPHA_SIZE)) begin
			code = 8'h31 + 8'(idx - 6'd52);
		end
		return code;
	endfunction

endpackage

[design/lcgx_key_char.sv]
// Key character unit: reduces a drawn generator value modulo 61 and maps
// the remainder to the key alphabet. Depends on lcgx_pkg.
module lcgx_key_char (
	input  logic [lcgx_pkg::DRAW_W-1:0] draw,
	output logic [7:0]                  key_char
);
	import lcgx_pkg::*;

	// 64 is 3 modulo 61, so each fold replaces the high part by three times it.
	logic [10:0] fold1;
	logic [7:0]  fold2;
	logic [6:0]  fold3;
	logic [5:0]  rem;

	always_comb begin
		fold1 = 11'(draw[14:6]) + 11'({draw[14:6], 1'b0}) + 11'(draw[5:0]);
		fold2 = 8'(fold1[10:6]) + 8'({fold1[10:6], 1'b0}) + 8'(fold1[5:0]);
		fold3 = 7'(fold2[7:6]) + 7'({fold2[7:6], 1'b0}) + 7'(fold2[5:0]);
		if (fold3 >= 7'(ALPHA_SIZE)) begin
			rem = 6'(fold3 - 7'(ALPHA_SIZE));
		end else begin
			rem = 6'(fold3);
		end
		key_char = alpha_char(rem);
	end

endmodule

[design/lcg_key_xor_stream_cipher.sv]
// Byte stream cipher: each word is XORed with a key character drawn from a
// linear congruential generator, then reused from a key memory.
// Pipeline: three register stages (s1, s2 and the output register); each
// accepted word passes through them in that order.
// Throughput: one word per cycle while m_tready holds; the generator register
// closes its loop with one constant multiply and add. A full pipeline stalls only on m_tready.
// Reset clears the generator, key position, key-complete flag and seed; the
// key memory is not cleared and needs no clearing pass.
// Depends on lcgx_pkg and lcgx_key_char.
module lcg_key_xor_stream_cipher #(
	parameter int unsigned KEY_LENGTH = lcgx_pkg::KEY_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,   // key_seed
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // data_in
	input  logic        s_tuser,    // first
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // data_out
	output logic        m_tlast
);
	import lcgx_pkg::*;

	localparam int unsigned PosW = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
	localparam logic [PosW-1:0] PosLast       = PosW'(KEY_LENGTH - 1);
	localparam logic [PosW-1:0] PosAfterFirst = PosW'(1 % KEY_LENGTH);

	logic [31:0]     seed_q;
	logic [31:0]     gen_q;
	logic [PosW-1:0] pos_q;
	logic            done_q;

	logic              v_s1, draw_s1, last_s1;
	logic [DRAW_W-1:0] rnd_s1;
	logic [PosW-1:0]   pos_s1;
	logic [7:0]        data_s1;

	logic       v_s2, draw_s2, last_s2;
	logic [7:0] key_s2, rd_s2, data_s2;

	logic       out_v_q, out_last_q;
	logic [7:0] out_data_q;

	logic [7:0] key_mem [KEY_LENGTH];

	logic            accept, adv1, adv2, adv_out;
	logic [31:0]     gen_base, gen_next;
	logic [PosW-1:0] pos_base, pos_next;
	logic            done_base, pos_wrap;
	logic [7:0]      key_char;

	assign cfg_ready = 1'b1;

	assign adv_out  = !out_v_q || m_tready;
	assign adv2     = !v_s2 || adv_out;
	assign adv1     = !v_s1 || adv2;
	assign s_tready = adv1;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		gen_base  = s_tuser ? seed_q : gen_q;
		pos_base  = s_tuser ? '0 : pos_q;
		done_base = s_tuser ? 1'b0 : done_q;
		gen_next  = gen_base * LCG_MUL + LCG_ADD;
		pos_wrap  = (pos_base == PosLast);
		pos_next  = pos_wrap ? '0 : pos_base + 1'b1;
	end

	lcgx_key_char u_key_char (
		.draw     (rnd_s1),
		.key_char (key_char)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= '0;
			gen_q   <= '0;
			pos_q   <= '0;
			done_q  <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				seed_q <= cfg_data;
			end
			if (accept) begin
				if (!done_base) begin
					gen_q <= gen_next;
				end
				pos_q  <= pos_next;
				done_q <= done_base || pos_wrap;
			end
			if (adv1) begin
				v_s1 <= accept;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				out_v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			draw_s1 <= !done_base;
			rnd_s1  <= gen_next[DRAW_LSB +: DRAW_W];
			pos_s1  <= pos_base;
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (adv2 && v_s1) begin
			draw_s2 <= draw_s1;
			key_s2  <= key_char;
			data_s2 <= data_s1;
			last_s2 <= last_s1;
		end
		if (adv_out && v_s2) begin
			out_data_q <= data_s2 ^ (draw_s2 ? key_s2 : rd_s2);
			out_last_q <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1 && draw_s1) begin
			key_mem[pos_s1] <= key_char;
		end
		if (adv2 && v_s1) begin
			rd_s2 <= key_mem[pos_s1];
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

`ifndef ASSERT_OFF
	a_first_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser |=> pos_q == PosAfterFirst)
		else $error("key position not restarted by a first word");

	a_done_at_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> pos_q == '0)
		else $error("key marked complete away from the wrap point");

	a_gen_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !s_tuser && done_q |=> $stable(gen_q))
		else $error("generator stepped after the key was complete");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv2 |=> v_s1 && $stable(pos_s1))
		else $error("stage one word lost under stall");
`endif

endmodule
